// ===== design/bdm_pkg.sv =====
// shared types, constants and command decode for the button multi-press decoder
package bdm_pkg;

   localparam int unsigned TIME_W        = 32;
   localparam int unsigned COUNT_W       = 8;
   localparam int unsigned CMD_W         = 3;
   localparam int unsigned CHAN_W        = 4;
   localparam int unsigned CSR_ADDR_W    = 2;
   localparam int unsigned CSR_DATA_W    = 16;
   localparam int unsigned REQ_DATA_W    = 40;
   localparam int unsigned RSP_DATA_W    = 24;

   localparam logic [TIME_W-1:0]  TOGGLE_HOLDOFF_MS = 32'd300;
   localparam logic [COUNT_W-1:0] COUNT_MAX         = 8'd255;

   localparam logic [COUNT_W-1:0] PRESSES_LEARN      = 8'd10;
   localparam logic [COUNT_W-1:0] PRESSES_DEL_CHAN   = 8'd12;
   localparam logic [COUNT_W-1:0] PRESSES_DEL_ALL    = 8'd16;
   localparam logic [COUNT_W-1:0] PRESSES_WIFI       = 8'd20;

   // command codes
   localparam logic [CMD_W-1:0] CMD_NONE       = 3'd0;
   localparam logic [CMD_W-1:0] CMD_LEARN      = 3'd1;
   localparam logic [CMD_W-1:0] CMD_DEL_CHAN   = 3'd2;
   localparam logic [CMD_W-1:0] CMD_DEL_ALL    = 3'd3;
   localparam logic [CMD_W-1:0] CMD_WIFI_SETUP = 3'd4;

   // register indexes
   localparam logic [CSR_ADDR_W-1:0] CSR_DEBOUNCE_MS      = 2'd0;
   localparam logic [CSR_ADDR_W-1:0] CSR_BURST_TIMEOUT_MS = 2'd1;
   localparam logic [CSR_ADDR_W-1:0] CSR_RADIO_PRESENT    = 2'd2;
   localparam logic [CSR_ADDR_W-1:0] CSR_CHANNEL_INDEX    = 2'd3;

   localparam logic [15:0]       DEBOUNCE_MS_RST      = 16'd50;
   localparam logic [15:0]       BURST_TIMEOUT_MS_RST = 16'd1000;

   typedef struct packed {
      logic [15:0]       debounce_ms;
      logic [15:0]       burst_timeout_ms;
      logic              radio_present;
      logic [CHAN_W-1:0] channel_index;
   } cfg_type;

   // one poll, now_ms in the low bits
   typedef struct packed {
      logic              relay_on;
      logic              pin_level;
      logic [TIME_W-1:0] now_ms;
   } req_item_type;

   // one result, toggle_relay in the low bits
   typedef struct packed {
      logic [CHAN_W-1:0]  channel;
      logic [CMD_W-1:0]   command;
      logic [COUNT_W-1:0] press_count;
      logic               burst_done;
      logic               relay_next;
      logic               toggle_relay;
   } rsp_item_type;

   function automatic logic [CMD_W-1:0] decode_command(input logic [COUNT_W-1:0] count,
                                                       input logic radio);
      logic [CMD_W-1:0] cmd;
      cmd = CMD_NONE;
      if (count == PRESSES_LEARN && radio) begin
         cmd = CMD_LEARN;
      end else if (count == PRESSES_DEL_CHAN && radio) begin
         cmd = CMD_DEL_CHAN;
      end else if (count == PRESSES_DEL_ALL && radio) begin
         cmd = CMD_DEL_ALL;
      end else if (count == PRESSES_WIFI) begin
         cmd = CMD_WIFI_SETUP;
      end
      return cmd;
   endfunction

endpackage

// ===== design/bdm_cfg.sv =====
// configuration registers written through the csr port
module bdm_cfg
   import bdm_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_we,
   input  logic [CSR_ADDR_W-1:0] csr_addr,
   input  logic [CSR_DATA_W-1:0] csr_wdata,
   output cfg_type               cfg
);

   cfg_type cfg_ff, cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         unique case (csr_addr)
            CSR_DEBOUNCE_MS:      cfg_in.debounce_ms      = csr_wdata;
            CSR_BURST_TIMEOUT_MS: cfg_in.burst_timeout_ms = csr_wdata;
            CSR_RADIO_PRESENT:    cfg_in.radio_present    = csr_wdata[0];
            CSR_CHANNEL_INDEX:    cfg_in.channel_index    = csr_wdata[CHAN_W-1:0];
            default:              cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.debounce_ms      <= DEBOUNCE_MS_RST;
         cfg_ff.burst_timeout_ms <= BURST_TIMEOUT_MS_RST;
         cfg_ff.radio_present    <= 1'b0;
         cfg_ff.channel_index    <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

// ===== design/bdm_core.sv =====
// debounce state, press counting, toggle holdoff and burst decode for one poll
module bdm_core
   import bdm_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         step_en,
   input  req_item_type item,
   input  cfg_type      cfg,
   output rsp_item_type result
);

   logic               stable_level_ff, stable_level_in;
   logic               debouncing_ff, debouncing_in;
   logic [TIME_W-1:0]  debounce_start_ff, debounce_start_in;
   logic [TIME_W-1:0]  last_toggle_ff, last_toggle_in;
   logic [TIME_W-1:0]  burst_start_ff, burst_start_in;
   logic [COUNT_W-1:0] change_count_ff, change_count_in;

   logic              level_diff;
   logic              expire;
   logic              toggle;
   logic              done;
   logic [TIME_W-1:0] deadline;
   logic [TIME_W-1:0] holdoff_end;
   logic [TIME_W-1:0] idle_time;

   always_comb begin
      level_diff  = item.pin_level != stable_level_ff;
      // sums wrap at 32 bits before the compare
      deadline    = debounce_start_ff + {16'd0, cfg.debounce_ms};
      holdoff_end = last_toggle_ff + TOGGLE_HOLDOFF_MS;
      expire      = level_diff && debouncing_ff && (item.now_ms >= deadline);
      toggle      = expire && (item.now_ms > holdoff_end);

      stable_level_in   = expire ? item.pin_level : stable_level_ff;
      debounce_start_in = (level_diff && !debouncing_ff) ? item.now_ms : debounce_start_ff;
      debouncing_in     = (level_diff && !debouncing_ff) ? 1'b1
                        : (expire ? 1'b0 : debouncing_ff);
      last_toggle_in    = toggle ? item.now_ms : last_toggle_ff;
      burst_start_in    = expire ? item.now_ms : burst_start_ff;

      change_count_in = change_count_ff;
      if (expire && change_count_ff != COUNT_MAX) begin
         change_count_in = change_count_ff + 8'd1;
      end

      // burst test sees the count and start time left by this poll's acceptance
      idle_time = item.now_ms - burst_start_in;
      done      = (change_count_in != '0) && (idle_time > {16'd0, cfg.burst_timeout_ms});

      result.toggle_relay = toggle;
      result.relay_next   = item.relay_on ^ toggle;
      result.burst_done   = done;
      result.press_count  = done ? change_count_in : '0;
      result.command      = done ? decode_command(change_count_in, cfg.radio_present)
                                 : CMD_NONE;
      result.channel      = done ? cfg.channel_index : '0;

      if (done) begin
         change_count_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stable_level_ff   <= 1'b1;
         debouncing_ff     <= 1'b0;
         debounce_start_ff <= '0;
         last_toggle_ff    <= '0;
         burst_start_ff    <= '0;
         change_count_ff   <= '0;
      end else if (step_en) begin
         stable_level_ff   <= stable_level_in;
         debouncing_ff     <= debouncing_in;
         debounce_start_ff <= debounce_start_in;
         last_toggle_ff    <= last_toggle_in;
         burst_start_ff    <= burst_start_in;
         change_count_ff   <= change_count_in;
      end
   end

endmodule

// ===== design/button_debounce_multi_press_decoder.sv =====
// top level: poll register, decoder core and result register with stream handshakes
// Each poll (timestamp, raw pin level, relay level) gives exactly one result: a poll is
// taken into an input register, the debounce and burst decode run in one pass of
// combinational logic while the state registers update, and the result lands in an
// output register, from which it transfers on rsp. Both registers advance together, so a
// new poll is taken every cycle while rsp_tready stays high; when it drops, req_tready
// falls as soon as the input register holds a waiting poll. Configuration writes take
// effect on the next cycle and are meant to happen only while no poll is in flight.
module button_debounce_multi_press_decoder
   import bdm_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   // now_ms[31:0], pin_level[32], relay_on[33], zero fill[39:34]
   input  logic [REQ_DATA_W-1:0] req_tdata,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   // toggle_relay[0], relay_next[1], burst_done[2], press_count[10:3], command[13:11],
   // channel[17:14], zero fill[23:18]
   output logic [RSP_DATA_W-1:0] rsp_tdata,
   input  logic                  csr_we,
   input  logic [CSR_ADDR_W-1:0] csr_addr,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   localparam int unsigned REQ_ITEM_W = $bits(req_item_type);
   localparam int unsigned RSP_ITEM_W = $bits(rsp_item_type);

   cfg_type      cfg;
   req_item_type in_item_ff, in_item_in;
   logic         in_valid_ff, in_valid_in;
   rsp_item_type out_item_ff, out_item_in;
   logic         out_valid_ff, out_valid_in;
   rsp_item_type step_result;
   logic         out_free;
   logic         step_en;
   logic         req_xfer;

   assign out_free   = !out_valid_ff || rsp_tready;
   assign step_en    = in_valid_ff && out_free;
   assign req_tready = !in_valid_ff || out_free;
   assign req_xfer   = req_tvalid && req_tready;

   always_comb begin
      in_item_in   = req_xfer ? req_item_type'(req_tdata[REQ_ITEM_W-1:0]) : in_item_ff;
      in_valid_in  = req_xfer ? 1'b1 : (step_en ? 1'b0 : in_valid_ff);
      out_item_in  = step_en ? step_result : out_item_ff;
      out_valid_in = step_en ? 1'b1 : (rsp_tready ? 1'b0 : out_valid_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      in_item_ff  <= in_item_in;
      out_item_ff <= out_item_in;
   end

   bdm_cfg u_cfg (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_addr  (csr_addr),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   bdm_core u_core (
      .clock   (clock),
      .reset   (reset),
      .step_en (step_en),
      .item    (in_item_ff),
      .cfg     (cfg),
      .result  (step_result)
   );

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {{(RSP_DATA_W-RSP_ITEM_W){1'b0}}, out_item_ff};

endmodule

// ===== design/bdm_checker.sv =====
// port-level checks on the result stream of the multi-press decoder
module bdm_checker
   import bdm_pkg::*;
(
   input logic                  clock,
   input logic                  reset,
   input logic                  rsp_tvalid,
   input logic                  rsp_tready,
   input logic [RSP_DATA_W-1:0] rsp_tdata
);

   logic               done;
   logic [COUNT_W-1:0] count;
   logic [CMD_W-1:0]   cmd;
   logic [CHAN_W-1:0]  chan;

   assign done  = rsp_tdata[2];
   assign count = rsp_tdata[10:3];
   assign cmd   = rsp_tdata[13:11];
   assign chan  = rsp_tdata[17:14];

   // a pending result is not withdrawn
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid)
      else $error("rsp_tvalid dropped before transfer");

   // without a finished burst the report fields stay zero
   a_idle_fields: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !done |-> count == '0 && cmd == CMD_NONE && chan == '0)
      else $error("report fields set without burst_done");

   // a finished burst always has at least one press
   a_burst_count: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && done |-> count != '0)
      else $error("burst_done with zero press_count");

   // each command matches its press count
   a_cmd_count: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && cmd != CMD_NONE |->
         (cmd == CMD_LEARN && count == PRESSES_LEARN) ||
         (cmd == CMD_DEL_CHAN && count == PRESSES_DEL_CHAN) ||
         (cmd == CMD_DEL_ALL && count == PRESSES_DEL_ALL) ||
         (cmd == CMD_WIFI_SETUP && count == PRESSES_WIFI))
      else $error("command does not match press_count");

endmodule

bind button_debounce_multi_press_decoder bdm_checker u_bdm_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);
